[rtl/core/ogru_pkg.sv]
// Shared types, constants and helpers for the occupancy grid ray update block.
package ogru_pkg;
	localparam int RowBits  = 8;
	localparam int ColBits  = 8;
	localparam int CellBits = 16;
	localparam int AddrBits = RowBits + ColBits;
	localparam int CoordBits = 24;
	localparam int CfgIdxBits = 3;
	localparam int CfgDataBits = 16;

	localparam logic [CfgIdxBits-1:0] CfgCellsPerUnit = 3'd0;
	localparam logic [CfgIdxBits-1:0] CfgOriginRow    = 3'd1;
	localparam logic [CfgIdxBits-1:0] CfgOriginCol    = 3'd2;
	localparam logic [CfgIdxBits-1:0] CfgFreeInc      = 3'd3;
	localparam logic [CfgIdxBits-1:0] CfgOccInc       = 3'd4;

	localparam logic [1:0] StatusDone     = 2'd0;
	localparam logic [1:0] StatusStartOut = 2'd1;
	localparam logic [1:0] StatusEndOut   = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CONV,
		ST_CHECK,
		ST_START_RD,
		ST_START_WR,
		ST_END_RD,
		ST_END_WR,
		ST_WALK_RD,
		ST_WALK_WR,
		ST_READ_RD,
		ST_READ_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [CellBits-1:0] cell_value;
		logic [8:0]          cells_updated;
		logic [RowBits-1:0]  box_min_row;
		logic [ColBits-1:0]  box_min_col;
		logic [RowBits-1:0]  box_max_row;
		logic [ColBits-1:0]  box_max_col;
	} result_t;

	typedef struct packed {
		logic                 func;
		logic [CoordBits-1:0] start_x;
		logic [CoordBits-1:0] start_y;
		logic [CoordBits-1:0] end_x;
		logic [CoordBits-1:0] end_y;
		logic                 end_free;
		logic [RowBits-1:0]   read_row;
		logic [ColBits-1:0]   read_col;
	} request_t;

	// saturating add of a cell and a signed increment
	function automatic logic [CellBits-1:0] sat_add(input logic [CellBits-1:0] a,
			input logic [CellBits:0] inc);
		logic signed [CellBits+1:0] s;
		s = $signed({{2{a[CellBits-1]}}, a}) + $signed({inc[CellBits], inc});
		if (s > $signed({3'b000, {(CellBits-1){1'b1}}}))
			return {1'b0, {(CellBits-1){1'b1}}};
		else if (s < $signed({3'b111, {(CellBits-1){1'b0}}}))
			return {1'b1, {(CellBits-1){1'b0}}};
		else
			return s[CellBits-1:0];
	endfunction
endpackage

[rtl/core/ogru_req_if.sv]
// Valid/ready channel interfaces for requests and results.
interface ogru_req_if;
	import ogru_pkg::*;
	logic     valid;
	logic     ready;
	request_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ogru_rsp_if;
	import ogru_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/core/ogru_to_cell.sv]
// Registered world-to-cell conversion of one coordinate.
module ogru_to_cell (
	input  logic                              clk,
	input  logic [ogru_pkg::CoordBits-1:0]    coord,
	input  logic [ogru_pkg::CfgDataBits-1:0]  cells_per_unit,
	input  logic [7:0]                        origin,
	output logic                              inside_s1,
	output logic [7:0]                        cell_s1
);
	import ogru_pkg::*;
	logic signed [42:0] prod;
	logic signed [42:0] v;
	logic [42:0]        mag;
	logic signed [42:0] q;

	always_comb begin
		prod = $signed({{19{coord[CoordBits-1]}}, coord}) * $signed({27'd0, cells_per_unit});
		v    = prod + $signed({19'd0, origin, 16'd0}) + 43'sd32768;
		mag  = v[42] ? 43'(-v) : 43'(v);
		q    = v[42] ? -$signed({16'd0, mag[42:16]}) : $signed({16'd0, mag[42:16]});
	end

	always_ff @(posedge clk) begin
		inside_s1 <= (q >= 0) && (q < 43'sd256);
		cell_s1   <= q[7:0];
	end
endmodule

[rtl/core/occupancy_grid_ray_update.sv]
// Top level: log-odds occupancy grid with Bresenham ray update and cell read.
// channel | dir | payload
// req     | in  | func, start/end x/y, end_free, read_row, read_col
// rsp     | out | status, cell_value, cells_updated, box bounds
// cfg     | in  | cfg_we, cfg_idx, cfg_data
// After reset a clearing pass zeroes all 65536 cells, one per cycle; ready is low meanwhile.
// Each ray cell is one read and one write-back on the single-port grid memory.
// One transaction in flight; request ready is low until the result is taken.
module occupancy_grid_ray_update (
	input  logic                               clk,
	input  logic                               arst_n,
	ogru_req_if.sink                           req,
	ogru_rsp_if.source                         rsp,
	input  logic                               cfg_we,
	input  logic [ogru_pkg::CfgIdxBits-1:0]    cfg_idx,
	input  logic [ogru_pkg::CfgDataBits-1:0]   cfg_data
);
	import ogru_pkg::*;

	logic [CellBits-1:0] grid_mem [0:(1<<AddrBits)-1];
	logic [CellBits-1:0] rd_data_q;
	logic [AddrBits-1:0] mem_addr;
	logic                mem_we;
	logic [CellBits-1:0] mem_wdata;
	logic [AddrBits-1:0] clr_q;

	logic [15:0] cpu_q;
	logic [7:0]  org_row_q, org_col_q;
	logic [15:0] finc_q;
	logic [14:0] oinc_q;

	state_t state_q, state_d;
	request_t req_q;
	result_t  res_q;
	logic [7:0] min_r_q, min_c_q, max_r_q, max_c_q;
	logic [7:0] min_r_d, min_c_d, max_r_d, max_c_d;
	logic [7:0] sr_q, sc_q, er_q, ec_q, r_q, c_q;
	logic signed [9:0] err_q;
	logic [8:0] dr_q, dc_q, cnt_q;

	logic sr_in, sc_in, er_in, ec_in;
	logic [7:0] sr_c, sc_c, er_c, ec_c;

	ogru_to_cell u_sr (.clk, .coord(req_q.start_y), .cells_per_unit(cpu_q),
		.origin(org_row_q), .inside_s1(sr_in), .cell_s1(sr_c));
	ogru_to_cell u_sc (.clk, .coord(req_q.start_x), .cells_per_unit(cpu_q),
		.origin(org_col_q), .inside_s1(sc_in), .cell_s1(sc_c));
	ogru_to_cell u_er (.clk, .coord(req_q.end_y), .cells_per_unit(cpu_q),
		.origin(org_row_q), .inside_s1(er_in), .cell_s1(er_c));
	ogru_to_cell u_ec (.clk, .coord(req_q.end_x), .cells_per_unit(cpu_q),
		.origin(org_col_q), .inside_s1(ec_in), .cell_s1(ec_c));

	// Bresenham step, combinational on current position
	logic signed [10:0] e2;
	logic signed [9:0]  err_n;
	logic [7:0] r_n, c_n;
	logic       walk_done;
	always_comb begin
		e2    = {err_q, 1'b0};
		err_n = err_q;
		r_n   = r_q;
		c_n   = c_q;
		if (e2 >= -$signed({2'b0, dc_q})) begin
			err_n = err_n - $signed({1'b0, dc_q});
			r_n   = (er_q > sr_q) ? r_q + 8'd1 : r_q - 8'd1;
		end
		if (e2 <= $signed({2'b0, dr_q})) begin
			err_n = err_n + $signed({1'b0, dr_q});
			c_n   = (ec_q > sc_q) ? c_q + 8'd1 : c_q - 8'd1;
		end
		walk_done = (r_n == er_q) && (c_n == ec_q);
	end

	logic same_pt;
	assign same_pt = (sr_q == er_q) && (sc_q == ec_q);

	// bounding box after the points of this ray
	always_comb begin
		min_r_d = min_r_q;
		min_c_d = min_c_q;
		max_r_d = max_r_q;
		max_c_d = max_c_q;
		if (state_q == ST_CHECK && sr_in && sc_in) begin
			min_r_d = (sr_c < min_r_q) ? sr_c : min_r_q;
			min_c_d = (sc_c < min_c_q) ? sc_c : min_c_q;
			max_r_d = (sr_c > max_r_q) ? sr_c : max_r_q;
			max_c_d = (sc_c > max_c_q) ? sc_c : max_c_q;
			if (er_in && ec_in) begin
				min_r_d = (er_c < min_r_d) ? er_c : min_r_d;
				min_c_d = (ec_c < min_c_d) ? ec_c : min_c_d;
				max_r_d = (er_c > max_r_d) ? er_c : max_r_d;
				max_c_d = (ec_c > max_c_d) ? ec_c : max_c_d;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE:      if (req.valid) state_d = req.data.func ? ST_READ_RD : ST_CONV;
			ST_CONV:      state_d = ST_CHECK;
			ST_CHECK:     state_d = (sr_in && sc_in && er_in && ec_in) ? ST_START_RD : ST_OUT;
			ST_START_RD:  state_d = ST_START_WR;
			ST_START_WR:  state_d = req_q.end_free ? ST_WALK_RD : ST_END_RD;
			ST_END_RD:    state_d = ST_END_WR;
			ST_END_WR:    state_d = ST_WALK_RD;
			ST_WALK_RD:   state_d = (same_pt || walk_done) ? ST_OUT : ST_WALK_WR;
			ST_WALK_WR:   state_d = ST_WALK_RD;
			ST_READ_RD:   state_d = ST_READ_WAIT;
			ST_READ_WAIT: state_d = ST_OUT;
			ST_OUT:       if (rsp.ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = {r_q, c_q};
		mem_wdata = sat_add(rd_data_q, {finc_q[15], finc_q});
		unique case (state_q)
			ST_CLEAR: begin
				mem_addr  = clr_q;
				mem_we    = 1'b1;
				mem_wdata = '0;
			end
			ST_START_RD: mem_addr = {sr_q, sc_q};
			ST_START_WR: begin
				mem_addr = {sr_q, sc_q};
				mem_we   = 1'b1;
			end
			ST_END_RD: mem_addr = {er_q, ec_q};
			ST_END_WR: begin
				mem_addr  = {er_q, ec_q};
				mem_we    = 1'b1;
				mem_wdata = sat_add(rd_data_q, {2'b00, oinc_q});
			end
			ST_WALK_RD: mem_addr = {r_n, c_n};
			ST_WALK_WR: mem_we = 1'b1;
			ST_READ_RD: mem_addr = {req_q.read_row, req_q.read_col};
			default: ;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.data  = res_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			grid_mem[mem_addr] <= mem_wdata;
		rd_data_q <= grid_mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			cpu_q     <= 16'd5120;
			org_row_q <= 8'd128;
			org_col_q <= 8'd128;
			finc_q    <= 16'hFF98;
			oinc_q    <= 15'd217;
			min_r_q   <= 8'd255;
			min_c_q   <= 8'd255;
			max_r_q   <= 8'd0;
			max_c_q   <= 8'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				case (cfg_idx)
					CfgCellsPerUnit: cpu_q     <= cfg_data;
					CfgOriginRow:    org_row_q <= cfg_data[7:0];
					CfgOriginCol:    org_col_q <= cfg_data[7:0];
					CfgFreeInc:      finc_q    <= cfg_data;
					CfgOccInc:       oinc_q    <= cfg_data[14:0];
					default: ;
				endcase
			end
			min_r_q <= min_r_d;
			min_c_q <= min_c_d;
			max_r_q <= max_r_d;
			max_c_q <= max_c_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			req_q <= req.data;
		if (state_q == ST_CHECK) begin
			sr_q  <= sr_c;
			sc_q  <= sc_c;
			er_q  <= er_c;
			ec_q  <= ec_c;
			r_q   <= sr_c;
			c_q   <= sc_c;
			dr_q  <= (er_c > sr_c) ? {1'b0, er_c - sr_c} : {1'b0, sr_c - er_c};
			dc_q  <= (ec_c > sc_c) ? {1'b0, ec_c - sc_c} : {1'b0, sc_c - ec_c};
			err_q <= ((er_c > sr_c) ? $signed({2'b0, er_c - sr_c}) : $signed({2'b0, sr_c - er_c}))
				- ((ec_c > sc_c) ? $signed({2'b0, ec_c - sc_c}) : $signed({2'b0, sc_c - ec_c}));
			cnt_q <= 9'd1;
			res_q.status <= !(sr_in && sc_in) ? StatusStartOut :
				!(er_in && ec_in) ? StatusEndOut : StatusDone;
		end
		if (state_q == ST_END_WR && !same_pt)
			cnt_q <= cnt_q + 9'd1;
		if (state_q == ST_WALK_RD) begin
			r_q   <= r_n;
			c_q   <= c_n;
			err_q <= err_n;
			if (!(same_pt || walk_done))
				cnt_q <= cnt_q + 9'd1;
		end
		if (state_d == ST_OUT && state_q != ST_OUT) begin
			res_q.box_min_row <= min_r_d;
			res_q.box_min_col <= min_c_d;
			res_q.box_max_row <= max_r_d;
			res_q.box_max_col <= max_c_d;
			if (req_q.func) begin
				res_q.status        <= StatusDone;
				res_q.cell_value    <= rd_data_q;
				res_q.cells_updated <= 9'd0;
			end else begin
				res_q.cell_value    <= '0;
				res_q.cells_updated <= (state_q == ST_WALK_RD) ?
					cnt_q : 9'd0;
			end
		end
	end
endmodule

[rtl/core/ogru_checker.sv]
// Port-level checker for the ray update block, bound to the top level.
module ogru_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [1:0] status,
	input logic [8:0] cells_updated
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid)) else $error("request taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != 2'd0 |-> cells_updated == 9'd0)
		else $error("rejected ray updated cells");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !rsp_valid) else $error("result too early");
endmodule

bind occupancy_grid_ray_update ogru_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.status(rsp.data.status), .cells_updated(rsp.data.cells_updated)
);

[tb/ogru_tb_if.sv]
// Testbench time base; the channel interfaces come from the block's own interface file.
`timescale 1ns / 1ps

[tb/occupancy_grid_ray_update_tb.sv]
// Testbench for the ray update block: ray casts and cell reads checked against a grid model.
`timescale 1ns / 1ps
module occupancy_grid_ray_update_tb;
	import ogru_pkg::*;

	localparam longint CycleLimit = 3000000;
	localparam int PhaseItems = 165;

	class grid_model;
		logic [15:0] cell_mem [65536];
		bit          written [65536];
		int          written_list [$];
		result_t     pending_results [$];
		logic [7:0]  min_r, min_c, max_r, max_c;
		logic [15:0] cpu;
		logic [7:0]  org_r, org_c;
		logic [15:0] free_inc;
		logic [14:0] occ_inc;
		int          mismatches, rays, reads, rejects, saturations;

		function new();
			foreach (cell_mem[i]) cell_mem[i] = '0;
			min_r = 8'd255; min_c = 8'd255; max_r = 8'd0; max_c = 8'd0;
			cpu = 16'd5120; org_r = 8'd128; org_c = 8'd128;
			free_inc = 16'hFF98; occ_inc = 15'd217;
		endfunction

		function void set_reg(logic [CfgIdxBits-1:0] idx, logic [15:0] d);
			case (idx)
				CfgCellsPerUnit: cpu = d;
				CfgOriginRow: org_r = d[7:0];
				CfgOriginCol: org_c = d[7:0];
				CfgFreeInc: free_inc = d;
				CfgOccInc: occ_inc = d[14:0];
				default: ;
			endcase
		endfunction

		function longint to_cell(logic [23:0] coord, logic [7:0] org);
			longint v;
			v = longint'(org) * 65536 + longint'($signed(coord)) * longint'(cpu) + 32768;
			return v / 65536;
		endfunction

		function bit widen(longint r, longint c);
			if (r < 0 || r > 255 || c < 0 || c > 255)
				return 0;
			if (r < min_r) min_r = r[7:0];
			if (r > max_r) max_r = r[7:0];
			if (c < min_c) min_c = c[7:0];
			if (c > max_c) max_c = c[7:0];
			return 1;
		endfunction

		function void bump(longint r, longint c, longint inc);
			int idx;
			longint s;
			idx = int'(r) * 256 + int'(c);
			s = longint'($signed(cell_mem[idx])) + inc;
			if (s > 32767) begin
				s = 32767;
				saturations++;
			end
			if (s < -32768) begin
				s = -32768;
				saturations++;
			end
			cell_mem[idx] = s[15:0];
			if (!written[idx]) begin
				written[idx] = 1;
				written_list.insert(written_list.size(), idx);
			end
		endfunction

		function void note_request(request_t q);
			result_t e;
			longint sr, sc, er, ec, dr, dc, err, r, c, e2, finc;
			int cnt;
			e = '0;
			if (q.func) begin
				reads++;
				e.cell_value = cell_mem[{q.read_row, q.read_col}];
			end else begin
				rays++;
				cnt = 0;
				finc = longint'($signed(free_inc));
				sr = to_cell(q.start_y, org_r);
				sc = to_cell(q.start_x, org_c);
				if (!widen(sr, sc)) begin
					e.status = StatusStartOut;
					rejects++;
				end else begin
					er = to_cell(q.end_y, org_r);
					ec = to_cell(q.end_x, org_c);
					if (!widen(er, ec)) begin
						e.status = StatusEndOut;
						rejects++;
					end else begin
						cnt = 1;
						bump(sr, sc, finc);
						if (!q.end_free) begin
							bump(er, ec, longint'(occ_inc));
							if (er != sr || ec != sc) cnt++;
						end
						dr = (er > sr) ? er - sr : sr - er;
						dc = (ec > sc) ? sc - ec : ec - sc;
						err = dr + dc;
						r = sr;
						c = sc;
						while (!(r == er && c == ec)) begin
							e2 = 2 * err;
							if (e2 >= dc) begin
								err += dc;
								r += (er > sr) ? 1 : -1;
							end
							if (e2 <= dr) begin
								err += dr;
								c += (ec > sc) ? 1 : -1;
							end
							if (!(r == er && c == ec)) begin
								bump(r, c, finc);
								cnt++;
							end
						end
					end
				end
				e.cells_updated = cnt[8:0];
			end
			e.box_min_row = min_r;
			e.box_min_col = min_c;
			e.box_max_row = max_r;
			e.box_max_col = max_c;
			pending_results.insert(pending_results.size(), e);
		endfunction

		function void check_result(result_t a);
			result_t e;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction %p", a);
				return;
			end
			e = pending_results.pop_front();
			if (e.status !== a.status || e.cell_value !== a.cell_value ||
					e.cells_updated !== a.cells_updated || e.box_min_row !== a.box_min_row ||
					e.box_min_col !== a.box_min_col || e.box_max_row !== a.box_max_row ||
					e.box_max_col !== a.box_max_col) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: status %0d/%0d value %0d/%0d cells %0d/%0d ",
						"box %0d,%0d,%0d,%0d / %0d,%0d,%0d,%0d (exp/act)"},
						e.status, a.status, $signed(e.cell_value), $signed(a.cell_value),
						e.cells_updated, a.cells_updated, e.box_min_row, e.box_min_col,
						e.box_max_row, e.box_max_col, a.box_min_row, a.box_min_col,
						a.box_max_row, a.box_max_col);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxBits-1:0] cfg_idx;
	logic [CfgDataBits-1:0] cfg_data;
	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_cycles;
	longint cycles;
	grid_model model;

	ogru_req_if req_ch();
	ogru_rsp_if rsp_ch();

	occupancy_grid_ray_update u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				model.check_result(rsp_ch.data);
			if (req_ch.valid && req_ch.ready)
				model.note_request(req_ch.data);
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp_ch.ready = 1'b0;
			hold_cycles--;
		end else begin
			rsp_ch.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	function automatic request_t mk(logic f, int sx, int sy, int ex, int ey, logic ef,
			int rr = 0, int rc = 0);
		request_t q;
		q.func = f;
		q.start_x = sx[23:0];
		q.start_y = sy[23:0];
		q.end_x = ex[23:0];
		q.end_y = ey[23:0];
		q.end_free = ef;
		q.read_row = rr[7:0];
		q.read_col = rc[7:0];
		return q;
	endfunction

	// world coordinate that lands near a chosen cell under the current setting
	function automatic logic [23:0] coord_for(int cell_no, logic [7:0] org);
		longint v;
		longint span;
		span = 65536 / longint'(model.cpu);
		v = (longint'(cell_no - int'(org)) * 65536) / longint'(model.cpu);
		if (span > 1)
			v += longint'($urandom_range(0, int'(span / 2)));
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[23:0];
	endfunction

	function automatic request_t random_item();
		request_t q;
		logic [127:0] raw;
		int idx;
		int sel;
		raw = {$urandom, $urandom, $urandom, $urandom};
		q = raw[$bits(request_t)-1:0];
		sel = $urandom_range(0, 99);
		if (sel < 25 && model.written_list.size() > 0) begin
			q.func = 1'b1;
			idx = model.written_list[$urandom_range(0, model.written_list.size() - 1)];
			q.read_row = idx[15:8];
			q.read_col = idx[7:0];
		end else if (sel < 90) begin
			q.func = 1'b0;
			q.start_y = coord_for($urandom_range(0, 263) - 4, model.org_r);
			q.start_x = coord_for($urandom_range(0, 263) - 4, model.org_c);
			if ($urandom_range(0, 3) == 0) begin
				q.end_y = coord_for(int'(model.to_cell(q.start_y, model.org_r))
					+ $urandom_range(0, 6) - 3, model.org_r);
				q.end_x = coord_for(int'(model.to_cell(q.start_x, model.org_c))
					+ $urandom_range(0, 6) - 3, model.org_c);
			end else begin
				q.end_y = coord_for($urandom_range(0, 263) - 4, model.org_r);
				q.end_x = coord_for($urandom_range(0, 263) - 4, model.org_c);
			end
		end else begin
			q.func = 1'b0;
		end
		return q;
	endfunction

	task automatic send(request_t q);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.data = q;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid = 1'b0;
		while (model.pending_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [15:0] d);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = d;
		model.set_reg(idx, d);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply_setting(logic [15:0] cpu, logic [7:0] orow, logic [7:0] ocol,
			logic [15:0] finc, logic [14:0] oinc);
		write_reg(CfgCellsPerUnit, cpu);
		write_reg(CfgOriginRow, {8'd0, orow});
		write_reg(CfgOriginCol, {8'd0, ocol});
		write_reg(CfgFreeInc, finc);
		write_reg(CfgOccInc, {1'b0, oinc});
	endtask

	initial begin
		model = new();
		cycles = 0;
		hold_cycles = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default setting: 0.078125 cells per unit (5120/65536), origin at the grid centre
		send(mk(0, 0, 0, 0, 0, 0));
		send(mk(0, 0, 0, 0, 0, 1));
		send(mk(0, 0, 0, 1280, 0, 0));
		send(mk(0, 0, 0, 0, -1280, 0));
		send(mk(0, 0, 0, 1000, 1000, 0));
		send(mk(0, -1600, -1600, 1600, 1600, 1));
		send(mk(0, 64, 0, 200, 1600, 0));
		send(mk(0, 0, 64, 1600, 200, 0));
		send(mk(0, 1600, -1600, -1600, 1600, 0));
		send(mk(0, 8388607, 0, 0, 0, 0));
		send(mk(0, 0, -8388608, 0, 0, 0));
		send(mk(0, 0, 0, -8388608, 8388607, 0));
		send(mk(0, 0, 0, 12, 0, 0));
		send(mk(1, -1, -1, -1, -1, 1, 128, 128));
		send(mk(1, 0, 0, 0, 0, 0, 128, 228));
		send(mk(1, 0, 0, 0, 0, 0, 255, 255));
		send(mk(1, 0, 0, 0, 0, 0, 0, 0));
		send(mk(1, 0, 0, 0, 0, 0, 148, 148));

		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				drain();
				case (p)
					1: apply_setting(16'hFFFF, 8'd0, 8'd0, 16'h8000, 15'h7FFF);
					2: apply_setting(16'd1, 8'd255, 8'd255, 16'h0000, 15'd0);
					3: apply_setting(16'd256, 8'd100, 8'd50, 16'hFFFF, 15'd1);
					default: apply_setting(16'd2560, 8'd20, 8'd230, 16'hFF00, 15'd600);
				endcase
			end
			sender_idle_pct = (p == 1) ? 55 : (p == 3) ? 7 : 0;
			receiver_stall_pct = (p == 2) ? 55 : (p == 3) ? 7 : 0;
			if (p == 1) begin
				// near-zero negative coordinate truncates onto cell 0; heavy saturation
				send(mk(0, -1, -1, 200, 100, 0));
				send(mk(0, -1, -1, 200, 100, 0));
				send(mk(0, -1, -1, 200, 100, 0));
				send(mk(1, 0, 0, 0, 0, 0, 0, 0));
				hold_cycles = 400;
			end
			for (int i = 0; i < PhaseItems; i++) begin
				if (p == 3 && i == PhaseItems / 2)
					drain();
				send(random_item());
			end
		end
		drain();

		$display("rays %0d (rejected %0d), reads %0d, saturating adds %0d, cells written %0d",
			model.rays, model.rejects, model.reads, model.saturations,
			model.written_list.size());
		$display("five register settings, idle and stall mixes, one long result hold-off");
		if (model.mismatches == 0 && model.pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("mismatches %0d, outstanding %0d", model.mismatches,
				model.pending_results.size());
			$display("status: fail");
		end
		$finish;
	end
endmodule

[sim.f]
rtl/core/ogru_pkg.sv
rtl/core/ogru_req_if.sv
rtl/core/ogru_to_cell.sv
rtl/core/occupancy_grid_ray_update.sv
rtl/core/ogru_checker.sv
tb/ogru_tb_if.sv
tb/occupancy_grid_ray_update_tb.sv
